/* design/symbol_top_of_book_stats_defines.svh */
// assertion macros for the symbol top-of-book tracker checker
`ifndef SYMBOL_TOP_OF_BOOK_STATS_DEFINES_SVH
`define SYMBOL_TOP_OF_BOOK_STATS_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define SBT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// payload holds while a transfer is stalled
`define SBT_ASSERT_HOLD(lbl, vld, rdy, data, msg) \
  `SBT_ASSERT(lbl, vld && !rdy |=> vld && $stable(data), msg)

`endif

/* design/sbt_pkg.sv */
// shared types and constants of the symbol top-of-book tracker
`default_nettype none

package sbt_pkg;

  localparam int unsigned KeyW     = 64;
  localparam int unsigned PriceW   = 32;
  localparam int unsigned QtyW     = 32;
  localparam int unsigned TimeW    = 64;
  localparam int unsigned SumW     = 48;
  localparam int unsigned CountW   = 32;
  localparam int unsigned IdxOutW  = 6;
  localparam int unsigned SpreadW  = 33;
  localparam int unsigned InDataW  = 256;
  localparam int unsigned OutDataW = 232;

  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic              sell;
    logic [PriceW-1:0] price;
    logic [QtyW-1:0]   qty;
    logic [SumW-1:0]   lat_inc;
  } item_t;

  typedef struct packed {
    logic [PriceW-1:0] bid;
    logic [PriceW-1:0] ask;
    logic              ask_seen;
    logic [SumW-1:0]   volume;
    logic [CountW-1:0] count;
    logic [SumW-1:0]   latency;
  } stats_t;

  // first member in the top bits, so entry_index lands in the lowest bits
  typedef struct packed {
    logic [SumW-1:0]    latency_total_us;
    logic [CountW-1:0]  message_count;
    logic [SumW-1:0]    volume_total;
    logic [SpreadW-1:0] spread;
    logic               ask_seen;
    logic [PriceW-1:0]  top_ask;
    logic [PriceW-1:0]  top_bid;
    logic [IdxOutW-1:0] entry_index;
  } result_t;

endpackage

`default_nettype wire

/* design/sbt_front.sv */
// front stage: key normalisation and latency increment, one registered item
`default_nettype none

module sbt_front #(
  parameter int unsigned SymbolBytes = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [sbt_pkg::KeyW-1:0]    in_key_i,
  input  wire logic                        in_sell_i,
  input  wire logic [sbt_pkg::PriceW-1:0]  in_price_i,
  input  wire logic [sbt_pkg::QtyW-1:0]    in_qty_i,
  input  wire logic [sbt_pkg::TimeW-1:0]   in_sent_i,
  input  wire logic [sbt_pkg::TimeW-1:0]   in_now_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output sbt_pkg::item_t                   out_item_o
);

  logic [sbt_pkg::KeyW-1:0]  key_norm;
  logic                      key_stop;
  logic [sbt_pkg::TimeW:0]   diff;
  logic [sbt_pkg::SumW-1:0]  lat_inc;
  logic                      vld_q;
  sbt_pkg::item_t            item_q;
  sbt_pkg::item_t            item_d;

  // keep bytes up to the first zero byte, within the symbol length
  always_comb begin
    key_norm = '0;
    key_stop = 1'b0;
    for (int b = 0; b < 8; b++) begin
      if (b < int'(SymbolBytes) && !key_stop) begin
        if (in_key_i[8*b +: 8] == 8'd0) begin
          key_stop = 1'b1;
        end else begin
          key_norm[8*b +: 8] = in_key_i[8*b +: 8];
        end
      end
    end
  end

  // top bit is the borrow: now earlier than sent
  assign diff = {1'b0, in_now_i} - {1'b0, in_sent_i};

  always_comb begin
    if (diff[sbt_pkg::TimeW]) begin
      lat_inc = '0;
    end else if (|diff[sbt_pkg::TimeW-1:sbt_pkg::SumW]) begin
      lat_inc = '1;
    end else begin
      lat_inc = diff[sbt_pkg::SumW-1:0];
    end
  end

  always_comb begin
    item_d.key     = key_norm;
    item_d.sell    = in_sell_i;
    item_d.price   = in_price_i;
    item_d.qty     = in_qty_i;
    item_d.lat_inc = lat_inc;
  end

  assign in_ready_o  = !vld_q || out_ready_i;
  assign out_valid_o = vld_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

/* design/sbt_queue.sv */
// two-entry queue of classified items between front and back
`default_nettype none

module sbt_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  input  wire sbt_pkg::item_t push_item_i,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i,
  output sbt_pkg::item_t      pop_item_o
);

  sbt_pkg::item_t slot_q [2];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     fill_q;
  logic           push;
  logic           pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_item_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

/* design/sbt_back.sv */
// back end: key scan, entry allocation, statistics update and result register
`default_nettype none

module sbt_back #(
  parameter int unsigned TableEntries = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire sbt_pkg::item_t   in_item_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output sbt_pkg::result_t      out_res_o,
  output logic                  out_full_o
);

  localparam int unsigned CW = $clog2(TableEntries + 1);
  localparam int unsigned IW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam logic [CW-1:0] FullCount = CW'(TableEntries);

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StScan   = 4'b0010,
    StUpdate = 4'b0100,
    StFinish = 4'b1000
  } state_e;

  state_e                       state_q, state_d;
  sbt_pkg::item_t               cur_q;
  logic [CW-1:0]                scan_idx_q;
  logic [CW-1:0]                used_q;
  logic                         cmp_vld_q;
  logic [IW-1:0]                cmp_idx_q;
  logic [sbt_pkg::KeyW-1:0]     key_rd_q;
  logic [IW-1:0]                slot_q;
  logic                         full_q;
  logic                         alloc_q;
  sbt_pkg::stats_t              stat_rd_q;
  sbt_pkg::stats_t              upd_q;
  logic                         out_vld_q;
  sbt_pkg::result_t             out_res_q;
  logic                         out_full_q;

  logic [sbt_pkg::KeyW-1:0]     key_mem  [TableEntries];
  sbt_pkg::stats_t              stat_mem [TableEntries];

  logic                         take;
  logic                         hit;
  logic                         key_re;
  logic                         stat_re;
  logic                         alloc_we;
  logic                         miss_full;
  logic                         stat_we;
  logic                         out_load;
  sbt_pkg::stats_t              base;
  sbt_pkg::stats_t              upd_d;
  logic [sbt_pkg::SumW:0]       vol_sum;
  logic [sbt_pkg::SumW:0]       lat_sum;
  logic [sbt_pkg::SpreadW-1:0]  spread;
  sbt_pkg::result_t             res_d;

  assign in_ready_o = (state_q == StIdle);
  assign take       = in_valid_i && in_ready_o;
  assign hit        = cmp_vld_q && (key_rd_q == cur_q.key);

  always_comb begin
    state_d   = state_q;
    key_re    = 1'b0;
    stat_re   = 1'b0;
    alloc_we  = 1'b0;
    miss_full = 1'b0;
    stat_we   = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (take) begin
          state_d = StScan;
        end
      end
      StScan: begin
        priority if (hit) begin
          stat_re = 1'b1;
          state_d = StUpdate;
        end else if (scan_idx_q < used_q) begin
          key_re = 1'b1;
        end else if (used_q == FullCount) begin
          miss_full = 1'b1;
          state_d   = StFinish;
        end else begin
          alloc_we = 1'b1;
          state_d  = StUpdate;
        end
      end
      StUpdate: begin
        stat_we = 1'b1;
        state_d = StFinish;
      end
      StFinish: begin
        if (!out_vld_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // new entry starts from zero
  assign base = alloc_q ? '0 : stat_rd_q;

  always_comb begin
    upd_d = base;
    if (base.count != '1) begin
      upd_d.count = base.count + sbt_pkg::CountW'(1);
    end
    vol_sum      = {1'b0, base.volume} + (sbt_pkg::SumW + 1)'(cur_q.qty);
    upd_d.volume = vol_sum[sbt_pkg::SumW] ? '1 : vol_sum[sbt_pkg::SumW-1:0];
    lat_sum       = {1'b0, base.latency} + {1'b0, cur_q.lat_inc};
    upd_d.latency = lat_sum[sbt_pkg::SumW] ? '1 : lat_sum[sbt_pkg::SumW-1:0];
    if (!cur_q.sell) begin
      if (cur_q.price > base.bid) begin
        upd_d.bid = cur_q.price;
      end
    end else begin
      if (!base.ask_seen || cur_q.price < base.ask) begin
        upd_d.ask = cur_q.price;
      end
      upd_d.ask_seen = 1'b1;
    end
  end

  always_comb begin
    if ((upd_q.bid != '0) && upd_q.ask_seen) begin
      spread = {1'b0, upd_q.ask} - {1'b0, upd_q.bid};
    end else begin
      spread = '0;
    end
    if (full_q) begin
      res_d = '0;
    end else begin
      res_d.entry_index      = sbt_pkg::IdxOutW'(slot_q);
      res_d.top_bid          = upd_q.bid;
      res_d.top_ask          = upd_q.ask_seen ? upd_q.ask : '0;
      res_d.ask_seen         = upd_q.ask_seen;
      res_d.spread           = spread;
      res_d.volume_total     = upd_q.volume;
      res_d.message_count    = upd_q.count;
      res_d.latency_total_us = upd_q.latency;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      used_q     <= '0;
      scan_idx_q <= '0;
      cmp_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (take) begin
        scan_idx_q <= '0;
        cmp_vld_q  <= 1'b0;
      end else if (key_re) begin
        scan_idx_q <= scan_idx_q + CW'(1);
        cmp_vld_q  <= 1'b1;
      end else if (state_q == StScan) begin
        cmp_vld_q <= 1'b0;
      end
      if (alloc_we) begin
        used_q <= used_q + CW'(1);
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cur_q   <= in_item_i;
      full_q  <= 1'b0;
      alloc_q <= 1'b0;
    end
    if (key_re) begin
      key_rd_q  <= key_mem[scan_idx_q[IW-1:0]];
      cmp_idx_q <= scan_idx_q[IW-1:0];
    end
    if (stat_re) begin
      stat_rd_q <= stat_mem[cmp_idx_q];
      slot_q    <= cmp_idx_q;
    end
    if (alloc_we) begin
      key_mem[used_q[IW-1:0]] <= cur_q.key;
      slot_q  <= used_q[IW-1:0];
      alloc_q <= 1'b1;
    end
    if (miss_full) begin
      full_q <= 1'b1;
    end
    if (stat_we) begin
      stat_mem[slot_q] <= upd_d;
      upd_q            <= upd_d;
    end
    if (out_load) begin
      out_res_q  <= res_d;
      out_full_q <= full_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_res_q;
  assign out_full_o  = out_full_q;

endmodule

`default_nettype wire

/* design/symbol_top_of_book_stats.sv */
// top level of the per-symbol top-of-book statistics tracker
//
//   channel   direction  tdata                               tuser
//   s_axis    in         key, price, quantity, sent, now     side
//   m_axis    out        slot, bid, ask, spread, sums        table_full
//
// the back end scans entries in order up to the hit, all entries in use on a
// miss, and skips the update when the table is full; the key scan reads
// one entry per cycle from the key memory port
// reset clears the fill count and the control state, no clearing pass
// the front stage and a two-entry queue keep taking transfers, until they
// are full, while the back end works or a result waits on m_axis_tready
`default_nettype none

module symbol_top_of_book_stats #(
  parameter int unsigned TableEntries = 64,
  parameter int unsigned SymbolBytes  = 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // symbol_key, price, quantity, sent_time_us, now_time_us
  input  wire logic [sbt_pkg::InDataW-1:0]     s_axis_tdata,
  // side
  input  wire logic                            s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // entry_index, bid, ask, ask_seen, spread, volume_total,
  // message_count, latency_total_us
  output logic [sbt_pkg::OutDataW-1:0]         m_axis_tdata,
  // table_full
  output logic                                 m_axis_tuser
);

  logic             fr_valid;
  logic             fr_ready;
  sbt_pkg::item_t   fr_item;
  logic             q_valid;
  logic             q_ready;
  sbt_pkg::item_t   q_item;
  sbt_pkg::result_t res;

  sbt_front #(
    .SymbolBytes (SymbolBytes)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_key_i    (s_axis_tdata[63:0]),
    .in_sell_i   (s_axis_tuser),
    .in_price_i  (s_axis_tdata[95:64]),
    .in_qty_i    (s_axis_tdata[127:96]),
    .in_sent_i   (s_axis_tdata[191:128]),
    .in_now_i    (s_axis_tdata[255:192]),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_item_o  (fr_item)
  );

  sbt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_item_i  (fr_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_item_o   (q_item)
  );

  sbt_back #(
    .TableEntries (TableEntries)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_item_i   (q_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res),
    .out_full_o  (m_axis_tuser)
  );

  assign m_axis_tdata = res;

endmodule

`default_nettype wire

/* design/sbt_checker.sv */
// port-level checks of the top-of-book tracker and their binding
`default_nettype none
`include "symbol_top_of_book_stats_defines.svh"

module sbt_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        s_axis_tvalid,
  input wire logic                        s_axis_tready,
  input wire logic [sbt_pkg::InDataW-1:0] s_axis_tdata,
  input wire logic                        s_axis_tuser,
  input wire logic                        m_axis_tvalid,
  input wire logic                        m_axis_tready,
  input wire logic [sbt_pkg::OutDataW-1:0] m_axis_tdata,
  input wire logic                        m_axis_tuser
);

  sbt_pkg::result_t         res;
  logic [sbt_pkg::InDataW:0] in_word;
  logic                     out_drop;
  logic                     out_entry;
  logic                     no_ask;

  assign res       = m_axis_tdata;
  assign in_word   = {s_axis_tuser, s_axis_tdata};
  assign out_drop  = m_axis_tvalid && m_axis_tuser;
  assign out_entry = m_axis_tvalid && !m_axis_tuser;
  assign no_ask    = m_axis_tvalid && !res.ask_seen;

  `SBT_ASSERT_HOLD(a_in_hold, s_axis_tvalid, s_axis_tready, in_word, "input not held")
  `SBT_ASSERT_HOLD(a_out_hold, m_axis_tvalid, m_axis_tready, m_axis_tdata, "result not held")
  `SBT_ASSERT(a_full_zero, out_drop |-> m_axis_tdata == '0, "dropped result not zero")
  `SBT_ASSERT(a_no_ask, no_ask |-> res.top_ask == '0 && res.spread == '0, "ask without ask")
  `SBT_ASSERT(a_count, out_entry |-> res.message_count != '0, "entry result with zero count")

endmodule

bind symbol_top_of_book_stats sbt_checker u_sbt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
